// File: design/krsd_pkg.sv
package krsd_pkg;

    typedef enum logic [1:0] {
        DRV_IDLE    = 2'd0,
        DRV_CONTROL = 2'd1,
        DRV_STOPPED = 2'd2
    } drive_mode_t;

    typedef enum logic {
        STR_IDLE  = 1'b0,
        STR_STEER = 1'b1
    } steer_mode_t;

    typedef enum logic [2:0] {
        KEY_OTHER     = 3'd0,
        KEY_UP        = 3'd1,
        KEY_DECEL     = 3'd2,
        KEY_STEER_CCW = 3'd3,
        KEY_STEER_CW  = 3'd4,
        KEY_QUIT      = 3'd5
    } key_t;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [2:0] CFG_ACCEL_RATE       = 3'd0;
    localparam logic [2:0] CFG_STEER_RATE       = 3'd1;
    localparam logic [2:0] CFG_VEL_DECAY_STEP   = 3'd2;
    localparam logic [2:0] CFG_STEER_DECAY_STEP = 3'd3;
    localparam logic [2:0] CFG_VEL_DEADBAND     = 3'd4;
    localparam logic [2:0] CFG_STEER_DEADBAND   = 3'd5;
    localparam logic [2:0] CFG_STEER_LIMIT      = 3'd6;
    localparam logic [2:0] CFG_TIMEOUT_TICKS    = 3'd7;

    typedef struct packed {
        logic [15:0] accel_rate;
        logic [15:0] steer_rate;
        logic [11:0] vel_decay_step;
        logic [11:0] steer_decay_step;
        logic [11:0] vel_deadband;
        logic [11:0] steer_deadband;
        logic [14:0] steer_limit;
        logic [7:0]  timeout_ticks;
    } cfg_t;

    typedef struct packed {
        drive_mode_t        drive;
        steer_mode_t        steer;
        logic signed [15:0] velocity;
        logic signed [15:0] steering;
        logic [7:0]         idle_ticks;
    } state_t;

    localparam cfg_t CFG_RESET = '{
        accel_rate:       16'd717,
        steer_rate:       16'd819,
        vel_decay_step:   12'd8,
        steer_decay_step: 12'd4,
        vel_deadband:     12'd41,
        steer_deadband:   12'd20,
        steer_limit:      15'd2287,
        timeout_ticks:    8'd10
    };

    localparam state_t STATE_RESET = '{
        drive:      DRV_IDLE,
        steer:      STR_IDLE,
        velocity:   16'sd0,
        steering:   16'sd0,
        idle_ticks: 8'd0
    };

endpackage

// File: design/krsd_step.sv
module krsd_step
    import krsd_pkg::*;
(
    input  cfg_t        cfg,
    input  state_t      cur,
    input  logic        cmd,
    input  logic [2:0]  key,
    input  logic [15:0] elapsed,
    output state_t      nxt
);

    localparam logic [10:0] DT_MAX = 11'd1024;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] decay(input logic signed [15:0] v,
                                                  input logic [11:0] step,
                                                  input logic [11:0] band);
        logic signed [17:0] vx;
        logic signed [17:0] negv;
        logic [16:0]        mag;
        logic signed [17:0] moved;
        logic signed [15:0] r;
        vx    = {{2{v[15]}}, v};
        negv  = -vx;
        mag   = v[15] ? negv[16:0] : vx[16:0];
        moved = (v > 16'sd0) ? vx - $signed({6'b0, step}) : vx + $signed({6'b0, step});
        if (mag > {5'b0, band}) begin
            r = sat16(moved);
        end else begin
            r = 16'sd0;
        end
        return r;
    endfunction

    logic               active;
    logic [10:0]        dt;
    logic [15:0]        rate;
    logic [26:0]        prod;
    logic [26:0]        rounded;
    logic signed [17:0] delta;
    logic signed [17:0] vel_x;
    logic signed [17:0] str_x;
    logic signed [17:0] str_new;
    logic signed [17:0] lim;
    logic [7:0]         ticks_inc;
    logic               expired;

    assign active  = (cur.drive == DRV_CONTROL) || (cur.steer == STR_STEER);
    assign dt      = !active ? 11'd0 : ((elapsed > 16'(DT_MAX)) ? DT_MAX : elapsed[10:0]);
    assign rate    = (key == KEY_UP || key == KEY_DECEL) ? cfg.accel_rate : cfg.steer_rate;
    assign prod    = {11'b0, rate} * {16'b0, dt};
    assign rounded = prod + 27'd512;
    assign delta   = $signed({1'b0, rounded[26:10]});
    assign vel_x   = {{2{cur.velocity[15]}}, cur.velocity};
    assign str_x   = {{2{cur.steering[15]}}, cur.steering};
    assign lim     = $signed({3'b0, cfg.steer_limit});

    assign ticks_inc = (cur.idle_ticks != 8'hFF) ? cur.idle_ticks + 8'd1 : cur.idle_ticks;
    assign expired   = ticks_inc > cfg.timeout_ticks;

    always_comb begin
        nxt     = cur;
        str_new = str_x;
        if (cur.drive != DRV_STOPPED) begin
            if (cmd == CMD_KEY) begin
                nxt.idle_ticks = 8'd0;
                case (key)
                    KEY_UP: begin
                        nxt.drive    = DRV_CONTROL;
                        nxt.velocity = sat16(vel_x + delta);
                    end
                    KEY_DECEL: begin
                        nxt.drive    = DRV_CONTROL;
                        nxt.velocity = sat16(vel_x - delta);
                    end
                    KEY_STEER_CCW: begin
                        nxt.steer = STR_STEER;
                        str_new   = str_x + delta;
                    end
                    KEY_STEER_CW: begin
                        nxt.steer = STR_STEER;
                        str_new   = str_x - delta;
                    end
                    KEY_QUIT: begin
                        nxt.drive    = DRV_STOPPED;
                        nxt.velocity = 16'sd0;
                        str_new      = 18'sd0;
                    end
                    default: begin
                        nxt.drive = DRV_IDLE;
                        nxt.steer = STR_IDLE;
                    end
                endcase
                if (str_new > lim) begin
                    nxt.steering = lim[15:0];
                end else if (str_new < -lim) begin
                    nxt.steering = 16'(-lim);
                end else begin
                    nxt.steering = str_new[15:0];
                end
            end else begin
                nxt.idle_ticks = ticks_inc;
                if (cur.drive == DRV_IDLE) begin
                    nxt.velocity = decay(cur.velocity, cfg.vel_decay_step, cfg.vel_deadband);
                end else if (expired) begin
                    nxt.drive = DRV_IDLE;
                end
                if (cur.steer == STR_IDLE) begin
                    nxt.steering = decay(cur.steering, cfg.steer_decay_step,
                                         cfg.steer_deadband);
                end else if (expired) begin
                    nxt.steer = STR_IDLE;
                end
            end
        end
    end

endmodule

// File: design/key_ramp_setpoint_with_decay.sv
// channel  valid    ready    payload
// input    s_valid  s_ready  s_cmd, s_key, s_elapsed
// result   m_valid  m_ready  m_velocity, m_steering, m_halted, m_drive_active,
//                            m_steer_active
// config   cfg_wr_en  -      cfg_index, cfg_wdata
//
// one item per cycle sustained while results are taken; an accepted item reaches the result
// through the input register, then one pass through the ramp multiplier into the state register
// the state register is the result register; it holds while a result is stalled
// an input item is still taken while a result waits if the input register is empty, which then holds it
// synchronous active-low reset restores the register defaults and the idle state
module key_ramp_setpoint_with_decay
    import krsd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [2:0]         s_key,
    input  logic [15:0]        s_elapsed,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_velocity,
    output logic signed [15:0] m_steering,
    output logic               m_halted,
    output logic               m_drive_active,
    output logic               m_steer_active,

    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata
);

    cfg_t        cfg_reg;
    state_t      state_reg;
    state_t      state_next;
    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [2:0]  in_key_reg;
    logic [15:0] in_elapsed_reg;
    logic        m_valid_reg;
    logic        advance;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    krsd_step u_step (
        .cfg     (cfg_reg),
        .cur     (state_reg),
        .cmd     (in_cmd_reg),
        .key     (in_key_reg),
        .elapsed (in_elapsed_reg),
        .nxt     (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= STATE_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                state_reg   <= state_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg     <= s_cmd;
            in_key_reg     <= s_key;
            in_elapsed_reg <= s_elapsed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ACCEL_RATE:       cfg_reg.accel_rate       <= cfg_wdata;
                CFG_STEER_RATE:       cfg_reg.steer_rate       <= cfg_wdata;
                CFG_VEL_DECAY_STEP:   cfg_reg.vel_decay_step   <= cfg_wdata[11:0];
                CFG_STEER_DECAY_STEP: cfg_reg.steer_decay_step <= cfg_wdata[11:0];
                CFG_VEL_DEADBAND:     cfg_reg.vel_deadband     <= cfg_wdata[11:0];
                CFG_STEER_DEADBAND:   cfg_reg.steer_deadband   <= cfg_wdata[11:0];
                CFG_STEER_LIMIT:      cfg_reg.steer_limit      <= cfg_wdata[14:0];
                CFG_TIMEOUT_TICKS:    cfg_reg.timeout_ticks    <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_velocity     = state_reg.velocity;
    assign m_steering     = state_reg.steering;
    assign m_halted       = (state_reg.drive == DRV_STOPPED);
    assign m_drive_active = (state_reg.drive == DRV_CONTROL);
    assign m_steer_active = (state_reg.steer == STR_STEER);

    // quit is final
    assert property (@(posedge aclk) disable iff (!aresetn) m_halted |=> m_halted)
        else $error("halted state left");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_halted |-> (m_velocity == 16'sd0 && m_steering == 16'sd0))
        else $error("setpoints not zero after quit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(state_reg))
        else $error("state moved under a stalled result");

    assert property (@(posedge aclk) disable iff (!aresetn) !s_ready |-> in_valid_reg)
        else $error("input refused with empty input register");

endmodule
